FILE: rtl/lmhf_pkg.sv
// Shared types and constants for the line mark hole finder.
// No dependencies; the scan unit and the core import it.
package lmhf_pkg;

    localparam int LANES     = 8;   // lines handled per scan step (one RAM row)
    localparam int LANE_BITS = 3;

    // Request kinds carried on the slave tuser
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_GAP   = 2'd2,
        KIND_SWEEP = 2'd3
    } t_kind;

    // Block classification returned by a sweep
    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_RECYCLE = 2'd1,
        ST_UNAVAIL = 2'd2
    } t_status;

    // Input tdata layout
    localparam int IN_W       = 16;
    localparam int IN_IDX_LO  = 0;
    localparam int IN_MARK    = 7;
    localparam int IN_TOP_LO  = 8;

    // Output tdata layout
    localparam int OUT_W       = 48;
    localparam int OUT_FOUND   = 0;
    localparam int OUT_TOP_LO  = 1;
    localparam int OUT_BOT_LO  = 9;
    localparam int OUT_MARK_LO = 17;
    localparam int OUT_HOLE_LO = 25;
    localparam int OUT_UNAV_LO = 32;
    localparam int OUT_STAT_LO = 40;

    // Sequencer to scan unit controls
    typedef struct packed {
        logic start;     // load initial scan state
        logic step;      // consume one row of mark bits
        logic gap_mode;  // 1: downward gap search, 0: upward sweep
    } t_scan_ctl;

endpackage

FILE: rtl/lmhf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the packed line mark rows.
module lmhf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lmhf_scan_unit.sv
// Shared eight-lane scan step: gap search state walking down, sweep counters walking up.
// Depends on lmhf_pkg for the lane count and the control struct.
module lmhf_scan_unit import lmhf_pkg::*; #(
    parameter int LINE_COUNT = 128,
    parameter int RW         = 4,
    parameter int PW         = 8,
    parameter int CW         = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_ctl        i_ctl,
    input  logic [PW-1:0]    i_limit,
    input  logic [RW-1:0]    i_row,
    input  logic [LANES-1:0] i_bits,
    output logic             o_done,
    output logic             o_found,
    output logic [PW-1:0]    o_upper,
    output logic [PW-1:0]    o_lower,
    output logic [CW-1:0]    o_marked,
    output logic [CW-1:0]    o_holes,
    output logic [CW-1:0]    o_unavail
);

    logic          r_gap;
    logic          r_done;
    logic [1:0]    r_run;      // saturates at 2: only "none", "one" and "more" matter
    logic [PW-1:0] r_upper;
    logic [PW-1:0] r_lower;
    logic [PW-1:0] r_limit;
    logic          r_below;
    logic [CW-1:0] r_marked;
    logic [CW-1:0] r_holes;
    logic [CW-1:0] r_unavail;

    logic          n_done;
    logic [1:0]    n_run;
    logic [PW-1:0] n_upper;
    logic [PW-1:0] n_lower;
    logic          n_below;
    logic [CW-1:0] n_marked;
    logic [CW-1:0] n_holes;
    logic [CW-1:0] n_unavail;

    // Gap search: lanes from high to low, stop at the first marked line under a long run
    always_comb begin
        logic [PW-1:0] line;
        n_done  = r_done;
        n_run   = r_run;
        n_upper = r_upper;
        n_lower = r_lower;
        for (int l = LANES - 1; l >= 0; l--) begin
            line = PW'({i_row, LANE_BITS'(l)});
            if (!n_done && (line < r_limit)) begin
                if (i_bits[l]) begin
                    if (n_run == 2'd2) begin
                        n_lower = line + PW'(2);
                        n_done  = 1'b1;
                    end else begin
                        n_run   = 2'd0;
                        n_upper = line;
                    end
                end else if (n_run != 2'd2) begin
                    n_run = n_run + 2'd1;
                end
            end
        end
    end

    // Sweep: lanes from low to high, carry the mark of the line below
    always_comb begin
        logic [PW-1:0] line;
        n_below   = r_below;
        n_marked  = r_marked;
        n_holes   = r_holes;
        n_unavail = r_unavail;
        for (int l = 0; l < LANES; l++) begin
            line = PW'({i_row, LANE_BITS'(l)});
            if (32'(line) < LINE_COUNT) begin
                if (i_bits[l]) begin
                    n_marked = n_marked + CW'(1);
                end else if (n_below) begin
                    n_holes = n_holes + CW'(1);
                end
                if (i_bits[l] || n_below) begin
                    n_unavail = n_unavail + CW'(1);
                end
                n_below = i_bits[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap  <= 1'b0;
            r_done <= 1'b0;
            r_run  <= 2'd0;
        end else if (i_ctl.start) begin
            r_gap     <= i_ctl.gap_mode;
            r_done    <= i_ctl.gap_mode && (i_limit == '0);
            r_run     <= 2'd0;
            r_upper   <= i_limit;
            r_limit   <= i_limit;
            r_lower   <= '0;
            r_below   <= 1'b0;
            r_marked  <= '0;
            r_holes   <= '0;
            r_unavail <= '0;
        end else if (i_ctl.step) begin
            if (r_gap) begin
                r_done  <= n_done;
                r_run   <= n_run;
                r_upper <= n_upper;
                r_lower <= n_lower;
            end else begin
                r_below   <= n_below;
                r_marked  <= n_marked;
                r_holes   <= n_holes;
                r_unavail <= n_unavail;
            end
        end
    end

    assign o_done    = r_done;
    assign o_found   = (r_run != 2'd0);
    assign o_upper   = r_upper;
    assign o_lower   = r_lower;
    assign o_marked  = r_marked;
    assign o_holes   = r_holes;
    assign o_unavail = r_unavail;

endmodule

FILE: rtl/line_mark_hole_finder_core.sv
// Top level of the line mark hole finder: sequencer, mark RAM, row valid bits, result register.
// Depends on lmhf_pkg, lmhf_ram and lmhf_scan_unit.
//
// The block keeps one mark bit per line of a heap block, packed eight lines to a RAM row,
// and serves one request (transaction) at a time; s_axis_tready is high only while the
// sequencer is idle. Request kinds on s_axis_tuser: write one mark, clear all marks,
// search downward for a gap of free lines, sweep the block. A mark write reads its row and
// writes it back with the one mark changed; a gap search reads rows downward from top_line
// and stops at the first usable gap; a sweep reads every row. The single RAM read port
// yields one row of eight marks per cycle into the shared scan unit.
// Clear-all takes effect at once through one valid flip-flop per row; a row whose valid
// bit is low reads as unmarked, so no clearing pass is needed after reset. Results sit in
// an output register, so a new request may be accepted while the last result waits.
module line_mark_hole_finder_core import lmhf_pkg::*; #(
    parameter int LINE_COUNT = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // line_index[6:0], mark_value[7], top_line[15:8]
    input  logic [1:0]       s_axis_tuser,  // kind[1:0]
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // gap_found[0], gap_top[8:1], gap_bottom[16:9],
                                            // marked_lines[24:17], hole_count[31:25],
                                            // unusable_lines[39:32], block_status[41:40],
                                            // zero fill[47:42]
);

    localparam int ROWS = (LINE_COUNT + LANES - 1) / LANES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW   = $clog2(ROWS * LANES + 2);
    localparam int CW   = $clog2(LINE_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR_RD,
        S_WR_WB,
        S_SCAN,
        S_FIN
    } t_state;

    t_state                r_state;
    t_kind                 r_kind;
    logic [RW-1:0]         r_row;
    logic                  r_up;         // sweep walks rows upward, gap search downward
    logic                  r_more;       // rows left to read
    logic                  r_pend;       // a row read last cycle is on the RAM output
    logic                  r_pend_last;
    logic [RW-1:0]         r_pend_row;
    logic                  r_rdv;        // valid bit of the row on the RAM output
    logic [LANE_BITS-1:0]  r_lane;
    logic                  r_mark;
    logic [ROWS-1:0]       r_row_valid;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_data;

    t_kind                 w_kind;
    logic                  w_accept;
    logic [6:0]            w_idx;
    logic [RW+2:0]         w_idx_line;
    logic [7:0]            w_top;
    logic [PW-1:0]         w_limit;
    logic [PW-1:0]         w_limit_m1;
    logic                  w_idx_ok;
    logic [RW-1:0]         w_end_row;
    logic                  w_at_end;

    logic                  w_re;
    logic                  w_we;
    logic [LANES-1:0]      w_ram_q;
    logic [LANES-1:0]      w_bits;
    logic [LANES-1:0]      w_wdata;

    t_scan_ctl             w_ctl;
    logic                  w_scan_done;
    logic                  w_found;
    logic [PW-1:0]         w_upper;
    logic [PW-1:0]         w_lower;
    logic [CW-1:0]         w_marked;
    logic [CW-1:0]         w_holes;
    logic [CW-1:0]         w_unavail;

    t_status               n_status;
    logic [OUT_W-1:0]      n_out_data;
    logic                  n_out_free;

    // Unpack the request
    assign w_kind     = t_kind'(s_axis_tuser);
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_idx      = s_axis_tdata[IN_IDX_LO +: 7];
    assign w_idx_line = (RW + 3)'(w_idx);
    assign w_top      = s_axis_tdata[IN_TOP_LO +: 8];
    assign w_idx_ok   = (32'(w_idx) < LINE_COUNT);

    // Saturate the search start to the block size
    assign w_limit    = (32'(w_top) > LINE_COUNT) ? PW'(LINE_COUNT) : PW'(w_top);
    assign w_limit_m1 = w_limit - PW'(1);

    assign w_end_row  = r_up ? RW'(ROWS - 1) : '0;
    assign w_at_end   = (r_row == w_end_row);

    // RAM port use: the read address is always the current row
    assign w_re    = (r_state == S_WR_RD) || ((r_state == S_SCAN) && r_more);
    assign w_we    = (r_state == S_WR_WB);
    assign w_bits  = r_rdv ? w_ram_q : '0;

    always_comb begin
        w_wdata         = w_bits;
        w_wdata[r_lane] = r_mark;
    end

    lmhf_ram #(
        .WIDTH (LANES),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_row),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_row),
        .o_rdata (w_ram_q)
    );

    assign w_ctl.start    = w_accept && ((w_kind == KIND_GAP) || (w_kind == KIND_SWEEP));
    assign w_ctl.step     = (r_state == S_SCAN) && r_pend;
    assign w_ctl.gap_mode = (w_kind == KIND_GAP);

    lmhf_scan_unit #(
        .LINE_COUNT (LINE_COUNT),
        .RW         (RW),
        .PW         (PW),
        .CW         (CW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_limit   (w_limit),
        .i_row     (r_pend_row),
        .i_bits    (w_bits),
        .o_done    (w_scan_done),
        .o_found   (w_found),
        .o_upper   (w_upper),
        .o_lower   (w_lower),
        .o_marked  (w_marked),
        .o_holes   (w_holes),
        .o_unavail (w_unavail)
    );

    // Build the result word; fields a kind does not produce stay zero
    always_comb begin
        if (w_unavail == '0) begin
            n_status = ST_FREE;
        end else if (32'(w_unavail) < LINE_COUNT) begin
            n_status = ST_RECYCLE;
        end else begin
            n_status = ST_UNAVAIL;
        end
        n_out_data = '0;
        case (r_kind)
            KIND_GAP: begin
                if (w_found) begin
                    n_out_data[OUT_FOUND]         = 1'b1;
                    n_out_data[OUT_TOP_LO +: 8]   = 8'(w_upper);
                    n_out_data[OUT_BOT_LO +: 8]   = 8'(w_lower);
                end
            end
            KIND_SWEEP: begin
                n_out_data[OUT_MARK_LO +: 8] = 8'(w_marked);
                n_out_data[OUT_HOLE_LO +: 7] = 7'(w_holes);
                n_out_data[OUT_UNAV_LO +: 8] = 8'(w_unavail);
                n_out_data[OUT_STAT_LO +: 2] = n_status;
            end
            default: begin
                n_out_data = '0;
            end
        endcase
    end

    assign n_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_more      <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Load a finished result, or drop the one on the bus once it is taken
            if ((r_state == S_FIN) && n_out_free) begin
                r_out_valid <= 1'b1;
                r_out_data  <= n_out_data;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_re) begin
                r_rdv <= r_row_valid[r_row];
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind      <= w_kind;
                        r_pend      <= 1'b0;
                        r_pend_last <= 1'b0;
                        r_lane      <= w_idx_line[LANE_BITS-1:0];
                        r_mark      <= s_axis_tdata[IN_MARK];
                        case (w_kind)
                            KIND_WRITE: begin
                                r_row   <= w_idx_line[RW+2:LANE_BITS];
                                r_state <= w_idx_ok ? S_WR_RD : S_FIN;
                            end
                            KIND_CLEAR: begin
                                r_row_valid <= '0;
                                r_state     <= S_FIN;
                            end
                            KIND_GAP: begin
                                r_up    <= 1'b0;
                                r_row   <= w_limit_m1[RW+2:LANE_BITS];
                                r_more  <= (w_limit != '0);
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_up    <= 1'b1;
                                r_row   <= '0;
                                r_more  <= 1'b1;
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_WR_RD: begin
                    r_state <= S_WR_WB;
                end
                S_WR_WB: begin
                    r_row_valid[r_row] <= 1'b1;
                    r_state            <= S_FIN;
                end
                S_SCAN: begin
                    // Issue the next row while the scan unit consumes the previous one
                    r_pend      <= r_more;
                    r_pend_last <= r_more && w_at_end;
                    r_pend_row  <= r_row;
                    if (w_scan_done || (r_pend && r_pend_last)) begin
                        r_more  <= 1'b0;
                        r_state <= S_FIN;
                    end else if (r_more) begin
                        if (w_at_end) begin
                            r_more <= 1'b0;
                        end else if (r_up) begin
                            r_row <= r_row + RW'(1);
                        end else begin
                            r_row <= r_row - RW'(1);
                        end
                    end
                end
                S_FIN: begin
                    // Hold until the output register is free
                    if (n_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Every request keeps the sequencer busy in the cycle after acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sequencer ready right after accepting a request");

    // A missed gap reports zero bounds
    a_no_gap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[OUT_FOUND]) |->
        (m_axis_tdata[OUT_TOP_LO +: 8] == 8'd0) && (m_axis_tdata[OUT_BOT_LO +: 8] == 8'd0))
        else $error("gap bounds nonzero without a gap");

    // A free block has no unavailable lines and no marked lines
    a_free_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[OUT_STAT_LO +: 2] == ST_FREE)) |->
        (m_axis_tdata[OUT_UNAV_LO +: 8] == 8'd0) && (m_axis_tdata[OUT_MARK_LO +: 8] == 8'd0))
        else $error("free status with unavailable lines");

    // The scan unit only steps on a row read in the previous cycle
    a_step_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.step |-> $past(w_re))
        else $error("scan step without a row read");

endmodule
